// File: rtl/core/rgb_correlation_similarity_unit_assert.svh
// Assertion macros used by the correlation similarity checker.
`ifndef RGB_CORRELATION_SIMILARITY_UNIT_ASSERT_SVH
`define RGB_CORRELATION_SIMILARITY_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define RCS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rcs assertion failed");

// Implication that must hold in the same cycle.
`define RCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `RCS_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

// File: rtl/core/rcs_pkg.sv
// Package: constants and codes of the correlation similarity unit.
package rcs_pkg;

  localparam int unsigned RootSteps  = 18;
  localparam int unsigned RootShift  = 34;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned TW         = 18;
  localparam int unsigned ResW       = 32;
  localparam int unsigned RefW       = 8;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [TW-1:0]   TOne      = 18'h10000;
  localparam logic [ResW-1:0] AccOne    = 32'h0001_0000;
  localparam logic [LevelW-1:0] LevelRst = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_RED   = 2'd0,
    CFG_REF_GREEN = 2'd1,
    CFG_REF_BLUE  = 2'd2,
    CFG_POWER     = 2'd3
  } cfg_idx_e;

endpackage

// File: rtl/core/rcs_if.sv
// Interfaces: pixel request channel and result channel.
interface rcs_pixel_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] pixel_red;
  logic [W-1:0] pixel_green;
  logic [W-1:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface rcs_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] similarity;
  logic        zero_norm;

  modport source (output valid, similarity, zero_norm, input ready);
  modport sink   (input valid, similarity, zero_norm, output ready);
endinterface

// File: rtl/core/rgb_correlation_similarity_unit.sv
// Top level: streaming RGB Pearson correlation similarity, (1+r)^level in Q16.16.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  pixel_if  | in  | valid/ready        | pixel_red, pixel_green, pixel_blue
//  result_if | out | valid/ready        | similarity (Q16.16), zero_norm
//  cfg       | in  | cfg_we_i, no wait  | cfg_idx_i selects ref RGB or power level
//
//  One pixel request per cycle while nothing stalls; the pipe has four front
//  stages (deviations, products, sums, norm products), 18 root-search stages
//  (one magnitude bit each), one stage forming 1+r, one multiply per power step.
//  Reset clears valid bits and configuration only; no clearing pass.
//  A full stage holds while its successor cannot take; bubbles collapse, so a
//  stalled result lets the pipe keep filling behind it.
module rgb_correlation_similarity_unit #(
  parameter int unsigned COMPONENT_BITS = 8,
  parameter int unsigned MAX_LEVEL      = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rcs_pixel_if.sink                    pixel_if,
  rcs_result_if.source                 result_if,
  input  logic                         cfg_we_i,
  input  logic [rcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcs_pkg::RefW-1:0]     cfg_data_i
);
  localparam int unsigned B     = COMPONENT_BITS;
  localparam int unsigned DW    = B + 2;           // deviation, signed
  localparam int unsigned NW    = 2 * DW;          // norm squared / |dot|
  localparam int unsigned PW    = 2 * NW;          // nx * ny
  localparam int unsigned RW    = PW + rcs_pkg::RootShift;
  localparam int unsigned AW    = PW + rcs_pkg::TW;
  localparam int unsigned NS    = rcs_pkg::RootSteps;
  localparam int unsigned SRoot = 4;
  localparam int unsigned ST    = SRoot + NS;
  localparam int unsigned SPow  = ST + 1;
  localparam int unsigned N     = SPow + MAX_LEVEL;
  localparam int unsigned LW    = $clog2(MAX_LEVEL + 1);

  // configuration
  logic [rcs_pkg::RefW-1:0]   ref_red_q, ref_green_q, ref_blue_q;
  logic [rcs_pkg::LevelW-1:0] power_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_red_q   <= '0;
      ref_green_q <= '0;
      ref_blue_q  <= '0;
      power_q     <= rcs_pkg::LevelRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcs_pkg::CFG_REF_RED:   ref_red_q   <= cfg_data_i;
        rcs_pkg::CFG_REF_GREEN: ref_green_q <= cfg_data_i;
        rcs_pkg::CFG_REF_BLUE:  ref_blue_q  <= cfg_data_i;
        rcs_pkg::CFG_POWER:     power_q     <= cfg_data_i[rcs_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  // clamp the exponent to the depth of the power chain
  logic [LW-1:0] level;
  assign level = (int'(power_q) > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(power_q);

  // valid bits and stage enables
  logic [N-1:0] v_q;
  logic [N-1:0] en;

  assign en[N-1] = !v_q[N-1] || result_if.ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= pixel_if.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign pixel_if.ready = en[0];

  // stage 0: deviations scaled by 3
  logic [B-1:0]           pix [3];
  logic [B-1:0]           rfc [3];
  logic [DW-1:0]          psum, rsum;
  logic signed [DW-1:0]   dx_d [3], dy_d [3];
  logic signed [DW-1:0]   dx_q [3], dy_q [3];

  assign pix[0] = B'(pixel_if.pixel_red);
  assign pix[1] = B'(pixel_if.pixel_green);
  assign pix[2] = B'(pixel_if.pixel_blue);
  assign rfc[0] = B'(ref_red_q);
  assign rfc[1] = B'(ref_green_q);
  assign rfc[2] = B'(ref_blue_q);

  always_comb begin
    psum = DW'(pix[0]) + DW'(pix[1]) + DW'(pix[2]);
    rsum = DW'(rfc[0]) + DW'(rfc[1]) + DW'(rfc[2]);
    for (int i = 0; i < 3; i++) begin
      dx_d[i] = signed'((DW'(pix[i]) << 1) + DW'(pix[i]) - psum);
      dy_d[i] = signed'((DW'(rfc[i]) << 1) + DW'(rfc[i]) - rsum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // stage 1: per-channel products
  logic signed [NW-1:0] pxy_q [3], pxx_q [3], pyy_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pxy_q[i] <= dx_q[i] * dy_q[i];
        pxx_q[i] <= dx_q[i] * dx_q[i];
        pyy_q[i] <= dy_q[i] * dy_q[i];
      end
    end
  end

  // stage 2: dot product, norms, gray detection
  logic signed [NW:0] dot;
  logic [NW-1:0]      nx_d, ny_d;
  logic [NW-1:0]      nx_q, ny_q, adot_q;
  logic               neg2_q, zero2_q;

  always_comb begin
    dot  = (NW+1)'(pxy_q[0]) + (NW+1)'(pxy_q[1]) + (NW+1)'(pxy_q[2]);
    nx_d = unsigned'(pxx_q[0]) + unsigned'(pxx_q[1]) + unsigned'(pxx_q[2]);
    ny_d = unsigned'(pyy_q[0]) + unsigned'(pyy_q[1]) + unsigned'(pyy_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      adot_q  <= dot[NW] ? NW'(-dot) : NW'(dot);
      neg2_q  <= dot[NW];
      zero2_q <= (nx_d == '0) || (ny_d == '0);
    end
  end

  // stage 3: nx*ny and dot^2 scaled for an 17-bit fraction of |r|
  logic [RW-1:0]              rem   [NS+1];
  logic [AW-1:0]              racc  [NS+1];
  logic [rcs_pkg::TW-1:0]     rq    [NS+1];
  logic [PW-1:0]              rprod [NS+1];
  logic                       rneg  [NS+1];
  logic                       rzero [NS+1];
  logic [PW-1:0]              dsq;

  assign dsq = PW'(adot_q) * PW'(adot_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      rprod[0] <= PW'(nx_q) * PW'(ny_q);
      rem[0]   <= {dsq, rcs_pkg::RootShift'(0)};
      rneg[0]  <= neg2_q;
      rzero[0] <= zero2_q;
    end
  end
  assign racc[0] = '0;
  assign rq[0]   = '0;

  // root search: largest q with q^2 * nx * ny <= dot^2 * 2^34, msb first
  for (genvar j = 0; j < NS; j++) begin : g_root
    rcs_root_step #(
      .PW  (PW),
      .RW  (RW),
      .BIT (NS - 1 - j)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (en[SRoot+j]),
      .rem_i  (rem[j]),
      .acc_i  (racc[j]),
      .q_i    (rq[j]),
      .prod_i (rprod[j]),
      .rem_o  (rem[j+1]),
      .acc_o  (racc[j+1]),
      .q_o    (rq[j+1]),
      .prod_o (rprod[j+1])
    );

    always_ff @(posedge clk_i) begin
      if (en[SRoot+j]) begin
        rneg[j+1]  <= rneg[j];
        rzero[j+1] <= rzero[j];
      end
    end
  end

  // form t = 1 + r with |r| rounded half away from zero
  logic [rcs_pkg::TW-1:0]   mag;
  logic [rcs_pkg::ResW-1:0] pacc  [MAX_LEVEL+1];
  logic [rcs_pkg::TW-1:0]   pt    [MAX_LEVEL+1];
  logic                     pzero [MAX_LEVEL+1];

  assign mag = rcs_pkg::TW'(((rcs_pkg::TW+1)'(rq[NS]) + 1'b1) >> 1);

  always_ff @(posedge clk_i) begin
    if (en[ST]) begin
      pt[0]    <= rzero[NS] ? rcs_pkg::TOne
                : (rneg[NS] ? rcs_pkg::TOne - mag : rcs_pkg::TOne + mag);
      pzero[0] <= rzero[NS];
    end
  end
  assign pacc[0] = rcs_pkg::AccOne;

  // power chain: step k multiplies only while k < level
  for (genvar k = 0; k < MAX_LEVEL; k++) begin : g_pow
    rcs_pow_step u_step (
      .clk_i    (clk_i),
      .en_i     (en[SPow+k]),
      .active_i (int'(level) > k),
      .acc_i    (pacc[k]),
      .t_i      (pt[k]),
      .acc_o    (pacc[k+1]),
      .t_o      (pt[k+1])
    );

    always_ff @(posedge clk_i) begin
      if (en[SPow+k]) begin
        pzero[k+1] <= pzero[k];
      end
    end
  end

  assign result_if.valid      = v_q[N-1];
  assign result_if.similarity = pacc[MAX_LEVEL];
  assign result_if.zero_norm  = pzero[MAX_LEVEL];
endmodule

// File: rtl/core/rcs_root_step.sv
// One bit of the correlation magnitude root search, registered.
module rcs_root_step #(
  parameter int unsigned PW  = 40,
  parameter int unsigned RW  = 74,
  parameter int unsigned BIT = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [RW-1:0]                rem_i,
  input  logic [PW+rcs_pkg::TW-1:0]    acc_i,
  input  logic [rcs_pkg::TW-1:0]       q_i,
  input  logic [PW-1:0]                prod_i,
  output logic [RW-1:0]                rem_o,
  output logic [PW+rcs_pkg::TW-1:0]    acc_o,
  output logic [rcs_pkg::TW-1:0]       q_o,
  output logic [PW-1:0]                prod_o
);
  localparam int unsigned AW = PW + rcs_pkg::TW;

  logic [RW+1:0] trial;
  logic          fits;

  // (q + 2^b)^2 * prod - q^2 * prod = (prod*q) << (b+1) + prod << 2b
  assign trial = ((RW+2)'(acc_i) << (BIT + 1)) + ((RW+2)'(prod_i) << (2 * BIT));
  assign fits  = trial <= (RW+2)'(rem_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= fits ? rem_i - RW'(trial) : rem_i;
      acc_o  <= fits ? acc_i + (AW'(prod_i) << BIT) : acc_i;
      q_o    <= fits ? (q_i | (rcs_pkg::TW'(1) << BIT)) : q_i;
      prod_o <= prod_i;
    end
  end
endmodule

// File: rtl/core/rcs_pow_step.sv
// One rounded Q16.16 multiply of the power chain, saturating, registered.
module rcs_pow_step (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       active_i,
  input  logic [rcs_pkg::ResW-1:0]   acc_i,
  input  logic [rcs_pkg::TW-1:0]     t_i,
  output logic [rcs_pkg::ResW-1:0]   acc_o,
  output logic [rcs_pkg::TW-1:0]     t_o
);
  localparam int unsigned MW = rcs_pkg::ResW + rcs_pkg::TW;

  logic [MW-1:0]                    prod;
  logic [MW-rcs_pkg::FracBits-1:0]  scaled;
  logic [rcs_pkg::ResW-1:0]         sat;

  assign prod   = MW'(acc_i) * MW'(t_i) + (MW'(1) << (rcs_pkg::FracBits - 1));
  assign scaled = prod[MW-1:rcs_pkg::FracBits];
  assign sat    = (|scaled[MW-rcs_pkg::FracBits-1:rcs_pkg::ResW]) ? '1
                                                                   : scaled[rcs_pkg::ResW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_o <= active_i ? sat : acc_i;
      t_o   <= t_i;
    end
  end
endmodule

// File: rtl/core/rcs_checker.sv
// Checker on the ports of the correlation similarity unit, with its bind.
`include "rgb_correlation_similarity_unit_assert.svh"

module rcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] similarity_i,
  input logic        zero_norm_i
);
  `RCS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `RCS_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(similarity_i))
  `RCS_ASSERT_IMPL(a_gray_one, clk_i, rst_ni, out_valid_i && zero_norm_i, similarity_i == 32'h0001_0000)
  `RCS_ASSERT_IMPL(a_empty_ready, clk_i, rst_ni, !out_valid_i, in_ready_i)
endmodule

bind rgb_correlation_similarity_unit rcs_checker u_rcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pixel_if.ready),
  .out_valid_i  (result_if.valid),
  .out_ready_i  (result_if.ready),
  .similarity_i (result_if.similarity),
  .zero_norm_i  (result_if.zero_norm)
);

// File: dv/rgb_correlation_similarity_unit_tb.sv
// Testbench: RGB correlation similarity unit checked against its own predictor.
module rgb_correlation_similarity_unit_tb;

  // Expected result of one pixel request.
  typedef struct {
    logic [31:0] similarity;
    bit          zero_norm;
  } similarity_t;

  // Tracks the configuration and works out (1+r)^level for each accepted pixel.
  class similarity_scoreboard;
    bit [7:0]    ref_r;
    bit [7:0]    ref_g;
    bit [7:0]    ref_b;
    bit [3:0]    level;
    similarity_t pending[$];
    int          mismatches;

    function void reset_regs();
      ref_r = 0;
      ref_g = 0;
      ref_b = 0;
      level = rcs_pkg::LevelRst;
    endfunction

    function void write_reg(rcs_pkg::cfg_idx_e idx, bit [7:0] v);
      case (idx)
        rcs_pkg::CFG_REF_RED:   ref_r = v;
        rcs_pkg::CFG_REF_GREEN: ref_g = v;
        rcs_pkg::CFG_REF_BLUE:  ref_b = v;
        rcs_pkg::CFG_POWER:     level = v[3:0];
        default: ;
      endcase
    endfunction

    // Correlation magnitude is searched bit by bit: largest q with
    // q^2 * nx * ny <= dot^2 * 2^34, then rounded half away from zero.
    function similarity_t correlate(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      similarity_t       res;
      longint            dx[3];
      longint            dy[3];
      longint            sx;
      longint            sy;
      longint            dot;
      longint            nx;
      longint            ny;
      longint unsigned   adot;
      logic [127:0]      prod;
      logic [127:0]      rhs;
      longint unsigned   q;
      longint unsigned   c;
      longint unsigned   mag;
      logic [63:0]       t;
      logic [63:0]       acc;
      int                steps;
      sx = longint'(r) + g + b;
      sy = longint'(ref_r) + ref_g + ref_b;
      dx[0] = 3 * longint'(r) - sx;
      dx[1] = 3 * longint'(g) - sx;
      dx[2] = 3 * longint'(b) - sx;
      dy[0] = 3 * longint'(ref_r) - sy;
      dy[1] = 3 * longint'(ref_g) - sy;
      dy[2] = 3 * longint'(ref_b) - sy;
      dot = 0;
      nx = 0;
      ny = 0;
      for (int i = 0; i < 3; i++) begin
        dot += dx[i] * dy[i];
        nx += dx[i] * dx[i];
        ny += dy[i] * dy[i];
      end
      res.zero_norm = (nx == 0 || ny == 0);
      if (res.zero_norm) begin
        t = 64'h10000;
      end else begin
        adot = (dot < 0) ? -dot : dot;
        prod = 128'(nx) * 128'(ny);
        rhs = (128'(adot) * 128'(adot)) << rcs_pkg::RootShift;
        q = 0;
        for (int k = 17; k >= 0; k--) begin
          c = q | (64'd1 << k);
          if (c <= 64'h20000 && prod * 128'(c) * 128'(c) <= rhs) q = c;
        end
        mag = (q + 1) >> 1;
        t = (dot < 0) ? 64'h10000 - mag : 64'h10000 + mag;
      end
      steps = (level > 15) ? 15 : level;
      acc = 64'h10000;
      repeat (steps) begin
        acc = (acc * t + 64'h8000) >> 16;
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      end
      res.similarity = acc[31:0];
      return res;
    endfunction

    function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      pending.push_back(correlate(r, g, b));
    endfunction

    function void check_result(logic [31:0] sim, logic zn);
      similarity_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: similarity %h zero_norm %b", sim, zn);
        return;
      end
      exp_res = pending.pop_front();
      if (sim !== exp_res.similarity || zn !== exp_res.zero_norm) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: similarity exp %h got %h, zero_norm exp %b got %b",
                   exp_res.similarity, sim, exp_res.zero_norm, zn);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [rcs_pkg::CfgIdxW-1:0] cfg_idx;
  logic [rcs_pkg::RefW-1:0]    cfg_data;

  rcs_pixel_if #(.W(8)) pix_if ();
  rcs_result_if         res_if ();

  rgb_correlation_similarity_unit #(
    .COMPONENT_BITS(8),
    .MAX_LEVEL     (15)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pixel_if  (pix_if),
    .result_if (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  similarity_scoreboard sb;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic hold_on;
  event start_hold;

  // Drain margin after the last result; longer than the pipeline is deep.
  localparam int DrainCycles = 60;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #3_000_000;
    $display("rgb_correlation_similarity_unit_tb NOT OK");
    $finish;
  end

  // Receiver: stall at random, or hold off entirely during a pressure stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_on) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Count the pressure stretch in cycles of its own, apart from the sender.
  initial begin
    hold_on = 1'b0;
    forever begin
      @(start_hold);
      hold_on <= 1'b1;
      repeat (300) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.similarity, res_if.zero_norm);
  end

  // Offer one pixel request; idle cycle by cycle at the sender's rate, then hold until taken.
  task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_red   <= r;
    pix_if.pixel_green <= g;
    pix_if.pixel_blue  <= b;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    sb.note_pixel(r, g, b);
  endtask

  // Drop valid and wait until every expected result is back, plus the drain margin.
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all four registers back to back; call only while the block is idle.
  task automatic set_config(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] p);
    rcs_pkg::cfg_idx_e  idx[4];
    bit [7:0]  val[4];
    idx = '{rcs_pkg::CFG_REF_RED, rcs_pkg::CFG_REF_GREEN, rcs_pkg::CFG_REF_BLUE,
            rcs_pkg::CFG_POWER};
    val = '{r, g, b, p};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly random colours, with grey pixels, the reference itself and its
  // complement mixed in so that r reaches 0-norm, +1 and -1.
  task automatic send_random();
    int       kind;
    bit [7:0] v;
    kind = $urandom_range(99);
    v = 8'($urandom_range(255));
    if (kind < 70)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    else if (kind < 80)
      send_pixel(v, v, v);
    else if (kind < 90)
      send_pixel(sb.ref_r, sb.ref_g, sb.ref_b);
    else
      send_pixel(~sb.ref_r, ~sb.ref_g, ~sb.ref_b);
  endtask

  // Random reference and power, the extremes of the power now and then.
  task automatic random_config();
    bit [7:0] p;
    bit [7:0] v;
    case ($urandom_range(3))
      0: p = 0;
      1: p = 15;
      default: p = 8'($urandom_range(15));
    endcase
    if ($urandom_range(9) == 0) begin
      v = 8'($urandom_range(255));
      set_config(v, v, v, p);
    end else begin
      set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 p);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_ni = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= rcs_pkg::CFG_REF_RED;
    cfg_data <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel_red <= '0;
    pix_if.pixel_green <= '0;
    pix_if.pixel_blue <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: grey reference, so every result has zero norm.
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    drain();

    // Pure red reference at power 1: match, opposite, grey and primaries.
    set_config(8'd255, 8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd10, 8'd90);
    drain();

    // Highest power: r = +1 gives the largest value, r = -1 gives zero.
    set_config(8'd0, 8'd128, 8'd255, 8'd15);
    send_pixel(8'd0, 8'd128, 8'd255);
    send_pixel(8'd255, 8'd127, 8'd0);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd77, 8'd77, 8'd77);
    drain();

    // Power zero: always one, whatever r is; upper data bits are dropped.
    set_config(8'd12, 8'd250, 8'd3, 8'hF0);
    send_pixel(8'd250, 8'd3, 8'd12);
    send_pixel(8'd12, 8'd250, 8'd3);
    send_pixel(8'd128, 8'd128, 8'd128);
    drain();

    // Random part: three idling phases, three settings each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 12; rx_idle_pct = 58; end
        1: begin tx_idle_pct = 58; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        random_config();
        // Hold the receiver off while pixels keep coming, to fill the pipe.
        if (ph == 2 && blk == 1) -> start_hold;
        repeat (110) send_random();
        drain();
      end
    end

    if (sb.pending.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("rgb_correlation_similarity_unit_tb OK");
    end else begin
      $display("rgb_correlation_similarity_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rcs_pkg.sv
rtl/core/rcs_if.sv
rtl/core/rcs_root_step.sv
rtl/core/rcs_pow_step.sv
rtl/core/rgb_correlation_similarity_unit.sv
rtl/core/rcs_checker.sv
dv/rgb_correlation_similarity_unit_tb.sv
